/* design/ps2m_pkg.sv */
// Shared types, codes and command tables for the PS/2 mouse host engine.
// No dependencies; every other design file imports this package.
`default_nettype none

package ps2m_pkg;

  localparam int unsigned TickWidthDef = 16;
  localparam int unsigned PktWidth     = 28;
  localparam int unsigned AddrWidth    = 5;
  localparam int unsigned DataWidth    = 32;

  // Mouse protocol bytes
  localparam logic [7:0] ByteAck      = 8'hFA;
  localparam logic [7:0] ByteResend   = 8'hFE;
  localparam logic [7:0] CmdReset     = 8'hFF;
  localparam logic [7:0] CmdSetRate   = 8'hF3;
  localparam logic [7:0] CmdReadId    = 8'hF2;
  localparam logic [7:0] CmdScale11   = 8'hE6;
  localparam logic [7:0] CmdSetRes    = 8'hE8;
  localparam logic [7:0] CmdEnable    = 8'hF4;
  localparam logic [7:0] KnockRate1   = 8'd200;
  localparam logic [7:0] KnockRate2   = 8'd100;
  localparam logic [7:0] KnockRate3   = 8'd80;
  localparam logic [7:0] WheelId      = 8'd3;
  localparam logic [3:0] WheelMask    = 4'hF;
  localparam int unsigned SyncBit     = 3;

  // Init sequence steps
  localparam logic [3:0] StepIdle      = 4'd0;
  localparam logic [3:0] StepScaleA    = 4'd1;
  localparam logic [3:0] StepReset     = 4'd2;
  localparam logic [3:0] StepKnock1    = 4'd3;
  localparam logic [3:0] StepKnock2    = 4'd4;
  localparam logic [3:0] StepKnock3    = 4'd5;
  localparam logic [3:0] StepReadId    = 4'd6;
  localparam logic [3:0] StepSetRes    = 4'd7;
  localparam logic [3:0] StepScaleB    = 4'd8;
  localparam logic [3:0] StepSetRate   = 4'd9;
  localparam logic [3:0] StepEnable    = 4'd10;
  localparam logic [3:0] StepProbeId   = 4'd11;

  // Status codes
  localparam logic [2:0] StNone      = 3'd0;
  localparam logic [2:0] StInitOk    = 3'd1;
  localparam logic [2:0] StInitFail  = 3'd2;
  localparam logic [2:0] StProbeOk   = 3'd3;
  localparam logic [2:0] StProbeFail = 3'd4;

  typedef enum logic [1:0] {
    ActByte  = 2'd0,
    ActTick  = 2'd1,
    ActInit  = 2'd2,
    ActProbe = 2'd3
  } action_e;

  typedef enum logic [1:0] {
    PhIdle   = 2'd0,
    PhCmdAck = 2'd1,
    PhArgAck = 2'd2,
    PhReply  = 2'd3
  } phase_e;

  typedef enum logic [1:0] {
    PkByte0 = 2'd0,
    PkByte1 = 2'd1,
    PkByte2 = 2'd2,
    PkWheel = 2'd3
  } pkt_phase_e;

  typedef enum logic [2:0] {
    RegCmdTimeout   = 3'd0,
    RegResetTimeout = 3'd1,
    RegResendLimit  = 3'd2,
    RegSampleRate   = 3'd3,
    RegResolution   = 3'd4
  } cfg_reg_e;

  typedef struct packed {
    logic [15:0] cmd_timeout;
    logic [15:0] reset_timeout;
    logic [5:0]  resend_limit;
    logic [7:0]  sample_rate;
    logic [1:0]  resolution;
  } cfg_t;

  typedef struct packed {
    logic                tx_valid;
    logic [7:0]          tx_byte;
    logic                packet_valid;
    logic [PktWidth-1:0] packet;
    logic                link_ready;
    logic [7:0]          device_id;
    logic [2:0]          status;
  } res_t;

  function automatic logic [7:0] cmd_of(input logic [3:0] step);
    logic [7:0] c;
    unique case (step)
      StepScaleA, StepScaleB:             c = CmdScale11;
      StepReset:                          c = CmdReset;
      StepKnock1, StepKnock2, StepKnock3,
      StepSetRate:                        c = CmdSetRate;
      StepReadId, StepProbeId:            c = CmdReadId;
      StepSetRes:                         c = CmdSetRes;
      StepEnable:                         c = CmdEnable;
      default:                            c = 8'h00;
    endcase
    return c;
  endfunction

  function automatic logic [1:0] replies_of(input logic [3:0] step);
    logic [1:0] r;
    unique case (step)
      StepReset:               r = 2'd2;
      StepReadId, StepProbeId: r = 2'd1;
      default:                 r = 2'd0;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

/* design/ps2m_cfg_regs.sv */
// APB-style configuration register file for the PS/2 mouse host engine.
// Depends on ps2m_pkg for the register indexes and the cfg_t bundle.
`default_nettype none

module ps2m_cfg_regs (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           psel,
  input  wire logic                           penable,
  input  wire logic                           pwrite,
  input  wire logic [ps2m_pkg::AddrWidth-1:0] paddr,
  input  wire logic [ps2m_pkg::DataWidth-1:0] pwdata,
  output logic      [ps2m_pkg::DataWidth-1:0] prdata,
  output logic                                pready,
  output ps2m_pkg::cfg_t                      cfg_o
);
  import ps2m_pkg::*;

  cfg_t       cfg_q, cfg_d;
  logic [2:0] idx;
  logic       wr_en;

  assign idx    = paddr[AddrWidth-1:2];
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;
  assign cfg_o  = cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      unique case (idx)
        RegCmdTimeout:   cfg_d.cmd_timeout   = pwdata[15:0];
        RegResetTimeout: cfg_d.reset_timeout = pwdata[15:0];
        RegResendLimit:  cfg_d.resend_limit  = pwdata[5:0];
        RegSampleRate:   cfg_d.sample_rate   = pwdata[7:0];
        RegResolution:   cfg_d.resolution    = pwdata[1:0];
        default:         cfg_d = cfg_q;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      RegCmdTimeout:   prdata = DataWidth'(cfg_q.cmd_timeout);
      RegResetTimeout: prdata = DataWidth'(cfg_q.reset_timeout);
      RegResendLimit:  prdata = DataWidth'(cfg_q.resend_limit);
      RegSampleRate:   prdata = DataWidth'(cfg_q.sample_rate);
      RegResolution:   prdata = DataWidth'(cfg_q.resolution);
      default:         prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.cmd_timeout   <= 16'd100;
      cfg_q.reset_timeout <= 16'd2000;
      cfg_q.resend_limit  <= 6'd32;
      cfg_q.sample_rate   <= 8'd40;
      cfg_q.resolution    <= 2'd3;
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule

`default_nettype wire

/* design/ps2m_engine.sv */
// Command engine, init/probe sequencer and packet assembler state.
// One request updates the state in a single pass. Depends on ps2m_pkg.
`default_nettype none

module ps2m_engine #(
  parameter int unsigned TICK_WIDTH = ps2m_pkg::TickWidthDef
) (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           step_i,
  input  wire logic [1:0]     action_i,
  input  wire logic [7:0]     rx_byte_i,
  input  wire ps2m_pkg::cfg_t cfg_i,
  output ps2m_pkg::res_t      res_o
);
  import ps2m_pkg::*;

  localparam int unsigned CmpWidth = (TICK_WIDTH > 16) ? TICK_WIDTH : 16;

  logic [3:0]            seq_q, seq_d;
  phase_e                phase_q, phase_d;
  logic [TICK_WIDTH-1:0] tick_q, tick_d;
  logic [5:0]            resend_q, resend_d;
  logic [1:0]            ridx_q, ridx_d;
  logic [7:0]            id_q, id_d;
  logic                  ready_q, ready_d;
  logic [1:0]            probe_q, probe_d;
  pkt_phase_e            pkt_q, pkt_d;
  logic [PktWidth-1:0]   word_q, word_d;

  logic                  fin, fin_ok, start;
  logic [7:0]            fin_reply;
  logic [3:0]            start_step, fin_step;
  logic                  has_arg;
  logic [7:0]            arg;
  logic [CmpWidth-1:0]   limit;
  logic [TICK_WIDTH-1:0] tick_inc;
  logic [1:0]            ridx_inc;
  logic [7:0]            b;

  assign b = rx_byte_i;

  always_comb begin
    unique case (seq_q)
      StepKnock1:  begin has_arg = 1'b1; arg = KnockRate1; end
      StepKnock2:  begin has_arg = 1'b1; arg = KnockRate2; end
      StepKnock3:  begin has_arg = 1'b1; arg = KnockRate3; end
      StepSetRes:  begin has_arg = 1'b1; arg = 8'(cfg_i.resolution); end
      StepSetRate: begin has_arg = 1'b1; arg = cfg_i.sample_rate; end
      default:     begin has_arg = 1'b0; arg = 8'h00; end
    endcase
  end

  assign limit    = (seq_q == StepReset) ? CmpWidth'(cfg_i.reset_timeout)
                                         : CmpWidth'(cfg_i.cmd_timeout);
  assign tick_inc = (&tick_q) ? tick_q : tick_q + TICK_WIDTH'(1);
  assign ridx_inc = ridx_q + 2'd1;

  always_comb begin
    seq_d      = seq_q;
    phase_d    = phase_q;
    tick_d     = tick_q;
    resend_d   = resend_q;
    ridx_d     = ridx_q;
    id_d       = id_q;
    ready_d    = ready_q;
    probe_d    = probe_q;
    pkt_d      = pkt_q;
    word_d     = word_q;
    fin        = 1'b0;
    fin_ok     = 1'b0;
    fin_reply  = 8'h00;
    start      = 1'b0;
    start_step = StepIdle;
    fin_step   = seq_q;
    res_o      = '0;

    unique case (action_e'(action_i))
      ActByte: begin
        if (phase_q != PhIdle) begin
          unique case (phase_q)
            PhCmdAck: begin
              if (b == ByteAck) begin
                if (has_arg) begin
                  res_o.tx_valid = 1'b1;
                  res_o.tx_byte  = arg;
                  phase_d        = PhArgAck;
                  tick_d         = '0;
                end else if (replies_of(seq_q) != 2'd0) begin
                  phase_d = PhReply;
                  tick_d  = '0;
                  ridx_d  = 2'd0;
                end else begin
                  fin    = 1'b1;
                  fin_ok = 1'b1;
                end
              end else if (b == ByteResend && resend_q < cfg_i.resend_limit) begin
                resend_d       = resend_q + 6'd1;
                res_o.tx_valid = 1'b1;
                res_o.tx_byte  = cmd_of(seq_q);
              end
            end
            PhArgAck: begin
              if (b == ByteAck) begin
                if (replies_of(seq_q) != 2'd0) begin
                  phase_d = PhReply;
                  tick_d  = '0;
                  ridx_d  = 2'd0;
                end else begin
                  fin    = 1'b1;
                  fin_ok = 1'b1;
                end
              end
            end
            PhReply: begin
              ridx_d = ridx_inc;
              tick_d = '0;
              if (ridx_inc >= replies_of(seq_q)) begin
                fin       = 1'b1;
                fin_ok    = 1'b1;
                fin_reply = b;
              end
            end
            default: ;
          endcase
        end else if (ready_q && seq_q == StepIdle) begin
          // Packet assembly, synced on the always-one bit of byte 0
          unique case (pkt_q)
            PkByte0: begin
              if (b[SyncBit]) begin
                word_d = PktWidth'(b);
                pkt_d  = PkByte1;
              end
            end
            PkByte1: begin
              word_d[15:8] = word_q[15:8] | b;
              pkt_d        = PkByte2;
            end
            PkByte2: begin
              word_d[23:16] = word_q[23:16] | b;
              if (id_q == WheelId) begin
                pkt_d = PkWheel;
              end else begin
                res_o.packet_valid = 1'b1;
                res_o.packet       = word_d;
                pkt_d              = PkByte0;
              end
            end
            PkWheel: begin
              word_d[27:24]      = word_q[27:24] | (b[3:0] & WheelMask);
              res_o.packet_valid = 1'b1;
              res_o.packet       = word_d;
              pkt_d              = PkByte0;
            end
            default: pkt_d = PkByte0;
          endcase
        end
      end
      ActTick: begin
        if (phase_q != PhIdle) begin
          tick_d = tick_inc;
          if (CmpWidth'(tick_inc) >= limit || (&tick_inc)) begin
            fin = 1'b1;
          end
        end
      end
      ActInit: begin
        ready_d    = 1'b0;
        id_d       = 8'h00;
        start      = 1'b1;
        start_step = StepScaleA;
      end
      ActProbe: begin
        if (seq_q == StepIdle && phase_q == PhIdle) begin
          if (!ready_q) begin
            ready_d    = 1'b0;
            id_d       = 8'h00;
            start      = 1'b1;
            start_step = StepScaleA;
          end else if (probe_q < 2'd2) begin
            probe_d = probe_q + 2'd1;
          end else begin
            ready_d    = 1'b0;
            probe_d    = 2'd0;
            start      = 1'b1;
            start_step = StepProbeId;
          end
        end
      end
      default: ;
    endcase

    // Close out the current command and pick the next step
    if (fin) begin
      phase_d = PhIdle;
      if (fin_step == StepProbeId) begin
        seq_d = StepIdle;
        if (fin_ok && fin_reply == id_q) begin
          ready_d      = 1'b1;
          res_o.status = StProbeOk;
        end else begin
          res_o.status = StProbeFail;
        end
      end else if (!fin_ok && (fin_step == StepScaleA || fin_step == StepReadId ||
                               fin_step == StepSetRes || fin_step == StepScaleB ||
                               fin_step == StepSetRate)) begin
        seq_d        = StepIdle;
        res_o.status = StInitFail;
      end else begin
        if (fin_ok && fin_step == StepReadId) begin
          id_d = fin_reply;
        end
        if (fin_step >= StepEnable || fin_step == StepIdle) begin
          seq_d        = StepIdle;
          ready_d      = 1'b1;
          res_o.status = StInitOk;
        end else begin
          start      = 1'b1;
          start_step = fin_step + 4'd1;
        end
      end
    end

    if (start) begin
      seq_d          = start_step;
      phase_d        = PhCmdAck;
      tick_d         = '0;
      resend_d       = 6'd0;
      ridx_d         = 2'd0;
      res_o.tx_valid = 1'b1;
      res_o.tx_byte  = cmd_of(start_step);
    end

    res_o.link_ready = ready_d;
    res_o.device_id  = id_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seq_q    <= StepIdle;
      phase_q  <= PhIdle;
      tick_q   <= '0;
      resend_q <= 6'd0;
      ridx_q   <= 2'd0;
      id_q     <= 8'h00;
      ready_q  <= 1'b0;
      probe_q  <= 2'd0;
      pkt_q    <= PkByte0;
      word_q   <= '0;
    end else if (step_i) begin
      seq_q    <= seq_d;
      phase_q  <= phase_d;
      tick_q   <= tick_d;
      resend_q <= resend_d;
      ridx_q   <= ridx_d;
      id_q     <= id_d;
      ready_q  <= ready_d;
      probe_q  <= probe_d;
      pkt_q    <= pkt_d;
      word_q   <= word_d;
    end
  end

endmodule

`default_nettype wire

/* design/ps2_mouse_host_engine.sv */
// PS/2 mouse host engine top level: request register, engine, result register.
// Depends on ps2m_pkg, ps2m_cfg_regs and ps2m_engine.
`default_nettype none

// Each request (received byte, timer tick, init or probe) yields exactly one
// result. Requests are taken one per clock; an accepted request waits in the
// request register while the engine's next-state logic forms the result and
// the next engine state, and its result is loaded into the result register
// when the request advances, which a stall on the result side holds back.
// Throughput is set by that single-pass state update and stays one request
// per cycle while the result side does not stall. The user must write
// configuration over the APB-style port only while no request is in flight;
// the block does not enforce this. TICK_WIDTH sets the tick counter width.
module ps2_mouse_host_engine #(
  parameter int unsigned TICK_WIDTH = ps2m_pkg::TickWidthDef
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              in_valid_i,
  output logic                                   in_stall_o,
  input  wire logic [1:0]                        action_i,
  input  wire logic [7:0]                        rx_byte_i,
  output logic                                   out_valid_o,
  input  wire logic                              out_stall_i,
  output logic                                   tx_valid_o,
  output logic      [7:0]                        tx_byte_o,
  output logic                                   packet_valid_o,
  output logic      [ps2m_pkg::PktWidth-1:0]     packet_o,
  output logic                                   link_ready_o,
  output logic      [7:0]                        device_id_o,
  output logic      [2:0]                        status_o,
  input  wire logic                              psel,
  input  wire logic                              penable,
  input  wire logic                              pwrite,
  input  wire logic [ps2m_pkg::AddrWidth-1:0]    paddr,
  input  wire logic [ps2m_pkg::DataWidth-1:0]    pwdata,
  output logic      [ps2m_pkg::DataWidth-1:0]    prdata,
  output logic                                   pready
);
  import ps2m_pkg::*;

  cfg_t       cfg;
  res_t       res;
  logic       req_valid_q;
  logic [1:0] req_action_q;
  logic [7:0] req_byte_q;
  logic       advance;
  logic       out_valid_q;
  res_t       out_q;

  ps2m_cfg_regs u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  ps2m_engine #(
    .TICK_WIDTH (TICK_WIDTH)
  ) u_engine (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .step_i    (advance),
    .action_i  (req_action_q),
    .rx_byte_i (req_byte_q),
    .cfg_i     (cfg),
    .res_o     (res)
  );

  // Advance the held request when the result register is free or draining
  assign advance    = req_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = req_valid_q && !advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_valid_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (!in_stall_o) begin
        req_valid_q <= in_valid_i;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (!in_stall_o && in_valid_i) begin
      req_action_q <= action_i;
      req_byte_q   <= rx_byte_i;
    end
    if (advance) begin
      out_q <= res;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign tx_valid_o     = out_q.tx_valid;
  assign tx_byte_o      = out_q.tx_byte;
  assign packet_valid_o = out_q.packet_valid;
  assign packet_o       = out_q.packet;
  assign link_ready_o   = out_q.link_ready;
  assign device_id_o    = out_q.device_id;
  assign status_o       = out_q.status;

  a_advance_loads: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance |=> out_valid_o)
    else $error("result register not loaded after advance");

  a_packet_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && packet_valid_o |-> link_ready_o && !tx_valid_o)
    else $error("packet given while link not ready or during a command");

  a_ok_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o == StInitOk || status_o == StProbeOk) |-> link_ready_o)
    else $error("success status without ready link");

  a_fail_not_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o == StInitFail || status_o == StProbeFail)
      |-> !link_ready_o && !tx_valid_o)
    else $error("failure status with ready link or pending send");

endmodule

`default_nettype wire

/* tb/ps2m_checker.sv */
// Scoreboard for the PS/2 mouse host engine: watches the request, the result and the
// register port, predicts each result from its own model of the engine, compares it.
// Depends on ps2m_pkg.
module ps2m_checker (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  input  logic                           in_stall_i,
  input  logic [1:0]                     action_i,
  input  logic [7:0]                     rx_byte_i,
  input  logic                           out_valid_i,
  input  logic                           out_stall_i,
  input  logic                           tx_valid_i,
  input  logic [7:0]                     tx_byte_i,
  input  logic                           packet_valid_i,
  input  logic [ps2m_pkg::PktWidth-1:0]  packet_i,
  input  logic                           link_ready_i,
  input  logic [7:0]                     device_id_i,
  input  logic [2:0]                     status_i,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic                           pready,
  input  logic [ps2m_pkg::AddrWidth-1:0] paddr,
  input  logic [ps2m_pkg::DataWidth-1:0] pwdata,
  output int                             fail_count_o,
  output int                             pending_o
);
  timeunit 1ns;
  timeprecision 1ps;
  import ps2m_pkg::*;

  // register copies
  logic [15:0] cmd_limit;
  logic [15:0] rst_limit;
  logic [5:0]  resend_max;
  logic [7:0]  rate_arg;
  logic [1:0]  res_arg;

  // engine model
  logic [3:0]              init_step;
  phase_e                  wait_phase;
  logic [TickWidthDef-1:0] tick_cnt;
  logic [5:0]              resend_cnt;
  logic [1:0]              reply_cnt;
  logic [7:0]              mouse_id;
  logic                    linked;
  logic [1:0]              probe_cnt;
  pkt_phase_e              pkt_slot;
  logic [PktWidth-1:0]     pkt_word;

  res_t step_res;
  res_t mouse_results[$];
  int   fails = 0;

  assign fail_count_o = fails;

  function automatic logic [7:0] command_byte(input logic [3:0] step);
    case (step)
      StepScaleA, StepScaleB:                          return CmdScale11;
      StepReset:                                       return CmdReset;
      StepKnock1, StepKnock2, StepKnock3, StepSetRate: return CmdSetRate;
      StepReadId, StepProbeId:                         return CmdReadId;
      StepSetRes:                                      return CmdSetRes;
      StepEnable:                                      return CmdEnable;
      default:                                         return 8'h00;
    endcase
  endfunction

  function automatic logic [1:0] reply_total(input logic [3:0] step);
    case (step)
      StepReset:               return 2'd2;
      StepReadId, StepProbeId: return 2'd1;
      default:                 return 2'd0;
    endcase
  endfunction

  function automatic logic argument_of(input logic [3:0] step, output logic [7:0] arg);
    arg = 8'h00;
    case (step)
      StepKnock1:  arg = KnockRate1;
      StepKnock2:  arg = KnockRate2;
      StepKnock3:  arg = KnockRate3;
      StepSetRes:  arg = {6'd0, res_arg};
      StepSetRate: arg = rate_arg;
      default:     return 1'b0;
    endcase
    return 1'b1;
  endfunction

  task automatic send_cmd(input logic [3:0] step);
    init_step = step;
    wait_phase = PhCmdAck;
    tick_cnt = '0;
    resend_cnt = '0;
    reply_cnt = '0;
    step_res.tx_valid = 1'b1;
    step_res.tx_byte = command_byte(step);
  endtask

  task automatic begin_init();
    linked = 1'b0;
    mouse_id = '0;
    send_cmd(StepScaleA);
  endtask

  task automatic close_cmd(input logic ok, input logic [7:0] reply);
    wait_phase = PhIdle;
    if (init_step == StepProbeId) begin
      init_step = StepIdle;
      if (ok && reply == mouse_id) begin
        linked = 1'b1;
        step_res.status = StProbeOk;
      end else begin
        step_res.status = StProbeFail;
      end
    end else if (!ok && init_step inside {StepScaleA, StepReadId, StepSetRes,
                                          StepScaleB, StepSetRate}) begin
      init_step = StepIdle;
      step_res.status = StInitFail;
    end else begin
      if (ok && init_step == StepReadId) mouse_id = reply;
      if (init_step >= StepEnable || init_step == StepIdle) begin
        init_step = StepIdle;
        linked = 1'b1;
        step_res.status = StInitOk;
      end else begin
        send_cmd(init_step + 4'd1);
      end
    end
  endtask

  task automatic after_ack();
    if (reply_total(init_step) != 2'd0) begin
      wait_phase = PhReply;
      tick_cnt = '0;
      reply_cnt = '0;
    end else begin
      close_cmd(1'b1, 8'h00);
    end
  endtask

  task automatic engine_byte(input logic [7:0] b);
    logic [7:0] arg;
    case (wait_phase)
      PhCmdAck: begin
        if (b == ByteAck) begin
          if (argument_of(init_step, arg)) begin
            step_res.tx_valid = 1'b1;
            step_res.tx_byte = arg;
            wait_phase = PhArgAck;
            tick_cnt = '0;
          end else begin
            after_ack();
          end
        end else if (b == ByteResend && resend_cnt < resend_max) begin
          resend_cnt = resend_cnt + 6'd1;
          step_res.tx_valid = 1'b1;
          step_res.tx_byte = command_byte(init_step);
        end
      end
      PhArgAck: begin
        if (b == ByteAck) after_ack();
      end
      PhReply: begin
        reply_cnt = reply_cnt + 2'd1;
        tick_cnt = '0;
        if (reply_cnt >= reply_total(init_step)) close_cmd(1'b1, b);
      end
      default: ;
    endcase
  endtask

  task automatic engine_tick();
    logic [15:0] limit;
    limit = (init_step == StepReset) ? rst_limit : cmd_limit;
    if (tick_cnt != '1) tick_cnt = tick_cnt + 1'b1;
    if (tick_cnt >= limit || tick_cnt == '1) close_cmd(1'b0, 8'h00);
  endtask

  task automatic packet_byte(input logic [7:0] b);
    case (pkt_slot)
      PkByte0: begin
        // hunt for a first byte with the sync bit set
        if (b[SyncBit]) begin
          pkt_word = {20'd0, b};
          pkt_slot = PkByte1;
        end
      end
      PkByte1: begin
        pkt_word[15:8] = pkt_word[15:8] | b;
        pkt_slot = PkByte2;
      end
      PkByte2: begin
        pkt_word[23:16] = pkt_word[23:16] | b;
        if (mouse_id == WheelId) begin
          pkt_slot = PkWheel;
        end else begin
          step_res.packet_valid = 1'b1;
          step_res.packet = pkt_word;
          pkt_slot = PkByte0;
        end
      end
      default: begin
        pkt_word[27:24] = pkt_word[27:24] | (b[3:0] & WheelMask);
        step_res.packet_valid = 1'b1;
        step_res.packet = pkt_word;
        pkt_slot = PkByte0;
      end
    endcase
  endtask

  task automatic predict_request(input action_e act, input logic [7:0] b);
    step_res = '0;
    case (act)
      ActByte: begin
        if (wait_phase != PhIdle) engine_byte(b);
        else if (linked && init_step == StepIdle) packet_byte(b);
      end
      ActTick: begin
        if (wait_phase != PhIdle) engine_tick();
      end
      ActInit: begin_init();
      default: begin
        if (init_step == StepIdle && wait_phase == PhIdle) begin
          if (!linked) begin
            begin_init();
          end else if (probe_cnt < 2'd2) begin
            probe_cnt = probe_cnt + 2'd1;
          end else begin
            linked = 1'b0;
            probe_cnt = '0;
            send_cmd(StepProbeId);
          end
        end
      end
    endcase
    step_res.link_ready = linked;
    step_res.device_id = mouse_id;
    mouse_results.push_back(step_res);
  endtask

  task automatic check_field(input string name, input logic [27:0] want,
                             input logic [27:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, want, got);
      fails++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    res_t want;
    if (!rst_ni) begin
      cmd_limit = 16'd100;
      rst_limit = 16'd2000;
      resend_max = 6'd32;
      rate_arg = 8'd40;
      res_arg = 2'd3;
      init_step = StepIdle;
      wait_phase = PhIdle;
      tick_cnt = '0;
      resend_cnt = '0;
      reply_cnt = '0;
      mouse_id = '0;
      linked = 1'b0;
      probe_cnt = '0;
      pkt_slot = PkByte0;
      pkt_word = '0;
      mouse_results.delete();
      pending_o <= 0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (mouse_results.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual status 0x%0h",
                   $time, status_i);
          fails++;
        end else begin
          want = mouse_results.pop_front();
          check_field("tx_valid", want.tx_valid, tx_valid_i);
          check_field("tx_byte", want.tx_byte, tx_byte_i);
          check_field("packet_valid", want.packet_valid, packet_valid_i);
          check_field("packet", want.packet, packet_i);
          check_field("link_ready", want.link_ready, link_ready_i);
          check_field("device_id", want.device_id, device_id_i);
          check_field("status", want.status, status_i);
        end
      end
      if (psel && penable && pwrite && pready) begin
        case (cfg_reg_e'(paddr[AddrWidth-1:2]))
          RegCmdTimeout:   cmd_limit = pwdata[15:0];
          RegResetTimeout: rst_limit = pwdata[15:0];
          RegResendLimit:  resend_max = pwdata[5:0];
          RegSampleRate:   rate_arg = pwdata[7:0];
          RegResolution:   res_arg = pwdata[1:0];
          default: ;
        endcase
      end
      if (in_valid_i && !in_stall_i) predict_request(action_e'(action_i), rx_byte_i);
      pending_o <= mouse_results.size();
    end
  end

endmodule

/* tb/tb_top.sv */
// Top of the PS/2 mouse host engine testbench: clock, reset, request stimulus,
// register setup and verdict. Depends on ps2m_pkg, ps2m_checker and the engine RTL.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import ps2m_pkg::*;

  localparam int unsigned IdleLimit = 4000;

  logic                 clk;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  action_e              act_drv = ActByte;
  logic [7:0]           rx_byte = 8'h00;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic                 tx_valid;
  logic [7:0]           tx_byte;
  logic                 packet_valid;
  logic [PktWidth-1:0]  packet;
  logic                 link_ready;
  logic [7:0]           device_id;
  logic [2:0]           status;
  logic                 psel = 1'b0;
  logic                 penable = 1'b0;
  logic                 pwrite = 1'b0;
  logic [AddrWidth-1:0] paddr = '0;
  logic [DataWidth-1:0] pwdata = '0;
  logic [DataWidth-1:0] prdata;
  logic                 pready;

  logic        calm = 1'b0;
  logic        wheel_hint = 1'b0;
  logic [7:0]  sent_id = 8'h00;
  int unsigned noise_pct = 10;
  int unsigned work_items = 0;
  int unsigned idle_cycles = 0;
  int          fail_count;
  int          pending;

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  ps2_mouse_host_engine dut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .in_valid_i     (in_valid),
    .in_stall_o     (in_stall),
    .action_i       (act_drv),
    .rx_byte_i      (rx_byte),
    .out_valid_o    (out_valid),
    .out_stall_i    (out_stall),
    .tx_valid_o     (tx_valid),
    .tx_byte_o      (tx_byte),
    .packet_valid_o (packet_valid),
    .packet_o       (packet),
    .link_ready_o   (link_ready),
    .device_id_o    (device_id),
    .status_o       (status),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready)
  );

  ps2m_checker chk (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .in_valid_i     (in_valid),
    .in_stall_i     (in_stall),
    .action_i       (act_drv),
    .rx_byte_i      (rx_byte),
    .out_valid_i    (out_valid),
    .out_stall_i    (out_stall),
    .tx_valid_i     (tx_valid),
    .tx_byte_i      (tx_byte),
    .packet_valid_i (packet_valid),
    .packet_i       (packet),
    .link_ready_i   (link_ready),
    .device_id_i    (device_id),
    .status_i       (status),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .pready         (pready),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .fail_count_o   (fail_count),
    .pending_o      (pending)
  );

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IdleLimit) begin
      $display("ps2_mouse_host_engine test failed");
      $finish;
    end
  end

  // result-side back-pressure in random bursts
  initial begin
    int unsigned burst;
    @(posedge rst_n);
    forever begin
      @(posedge clk);
      if (!calm && $urandom_range(0, 11) == 0) begin
        out_stall <= 1'b1;
        burst = $urandom_range(1, 19);
        repeat (burst) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  function automatic logic [7:0] rand_byte();
    return 8'($urandom_range(0, 255));
  endfunction

  function automatic logic [7:0] pick_id();
    int unsigned roll;
    roll = $urandom_range(0, 9);
    if (roll < 6) return WheelId;
    if (roll < 9) return 8'h00;
    return rand_byte();
  endfunction

  // Hold the request until accepted; leave valid high so back-to-back requests flow.
  task automatic send_req(input action_e act, input logic [7:0] b, input bit counted);
    int unsigned gap;
    gap = 0;
    if (!calm && $urandom_range(0, 7) == 0) gap = $urandom_range(1, 19);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    act_drv <= act;
    rx_byte <= b;
    do @(posedge clk); while (in_stall);
    if (counted) work_items++;
  endtask

  task automatic ack_with_noise();
    logic [7:0] stray;
    if ($urandom_range(0, 99) < noise_pct) begin
      case ($urandom_range(0, 2))
        0: repeat ($urandom_range(1, 3)) send_req(ActByte, ByteResend, 1'b1);
        1: begin
          do stray = rand_byte(); while (stray == ByteAck || stray == ByteResend);
          send_req(ActByte, stray, 1'b0);
        end
        default: repeat ($urandom_range(1, 3)) send_req(ActTick, rand_byte(), 1'b1);
      endcase
    end
    send_req(ActByte, ByteAck, 1'b1);
  endtask

  task automatic init_script(input logic [7:0] id, input int unsigned storm);
    send_req(ActInit, rand_byte(), 1'b1);
    repeat (storm) send_req(ActByte, ByteResend, 1'b1);
    ack_with_noise();
    ack_with_noise();
    repeat (2) send_req(ActByte, rand_byte(), 1'b1);
    repeat (6) ack_with_noise();
    ack_with_noise();
    send_req(ActByte, id, 1'b1);
    repeat (6) ack_with_noise();
    sent_id = id;
    wheel_hint = (id == WheelId);
  endtask

  task automatic packet_burst(input int unsigned n);
    repeat (n) begin
      if ($urandom_range(0, 7) == 0) send_req(ActByte, rand_byte() & 8'hF7, 1'b0);
      send_req(ActByte, rand_byte() | 8'(1 << SyncBit), 1'b1);
      repeat (wheel_hint ? 3 : 2) send_req(ActByte, rand_byte(), 1'b1);
    end
  endtask

  task automatic probe_script();
    repeat (3) send_req(ActProbe, rand_byte(), 1'b1);
    ack_with_noise();
    send_req(ActByte, ($urandom_range(0, 3) != 0) ? sent_id : rand_byte(), 1'b1);
  endtask

  task automatic cfg_write(input cfg_reg_e idx, input logic [DataWidth-1:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= AddrWidth'(idx) << 2;
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_config(input logic [15:0] cmd_to, input logic [15:0] rst_to,
                            input logic [5:0] resends, input logic [7:0] rate,
                            input logic [1:0] res);
    // drain every outstanding result before touching the registers
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (4) @(posedge clk);
    cfg_write(RegCmdTimeout, DataWidth'(cmd_to));
    cfg_write(RegResetTimeout, DataWidth'(rst_to));
    cfg_write(RegResendLimit, DataWidth'(resends));
    cfg_write(RegSampleRate, DataWidth'(rate));
    cfg_write(RegResolution, DataWidth'(res));
  endtask

  task automatic run_phase(input int unsigned target);
    int unsigned start;
    int unsigned pick;
    start = work_items;
    while (work_items - start < target) begin
      pick = $urandom_range(0, 99);
      if (pick < 25) begin
        init_script(pick_id(), 0);
        packet_burst($urandom_range(1, 4));
      end else if (pick < 50) begin
        packet_burst($urandom_range(1, 6));
      end else if (pick < 65) begin
        probe_script();
      end else if (pick < 75) begin
        init_script(pick_id(), $urandom_range(0, 70));
      end else if (pick < 85) begin
        repeat ($urandom_range(1, 8)) send_req(ActTick, rand_byte(), 1'b0);
      end else begin
        repeat ($urandom_range(1, 6))
          send_req(action_e'($urandom_range(0, 3)), rand_byte(), 1'b0);
      end
    end
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // idle, not ready: byte and tick are dropped
    send_req(ActByte, 8'hFF, 1'b0);
    send_req(ActTick, 8'h00, 1'b0);
    // probe while not ready starts init, init while busy restarts it
    send_req(ActProbe, 8'h55, 1'b1);
    send_req(ActInit, 8'hAA, 1'b1);
    send_req(ActProbe, 8'h00, 1'b0);
    send_req(ActByte, ByteResend, 1'b1);
    send_req(ActByte, 8'h00, 1'b0);
    send_req(ActByte, ByteAck, 1'b1);
    send_req(ActByte, ByteAck, 1'b1);
    send_req(ActByte, 8'hAA, 1'b1);
    send_req(ActByte, 8'h00, 1'b1);
    repeat (7) send_req(ActByte, ByteAck, 1'b1);
    send_req(ActByte, WheelId, 1'b1);
    repeat (6) send_req(ActByte, ByteAck, 1'b1);
    sent_id = WheelId;
    wheel_hint = 1'b1;
    // out of sync byte, then a full wheel packet at the extremes
    send_req(ActByte, 8'h00, 1'b0);
    send_req(ActByte, 8'hFF, 1'b1);
    send_req(ActByte, 8'h00, 1'b1);
    send_req(ActByte, 8'hFF, 1'b1);
    send_req(ActByte, 8'hFF, 1'b1);

    noise_pct = 10;
    run_phase(200);

    noise_pct = 15;
    set_config(16'd1, 16'd1, 6'd0, 8'd0, 2'd0);
    run_phase(200);

    noise_pct = 20;
    set_config(16'hFFFF, 16'hFFFF, 6'd63, 8'd255, 2'd3);
    run_phase(250);

    noise_pct = 25;
    set_config(16'($urandom_range(1, 6)), 16'($urandom_range(1, 6)),
               6'($urandom_range(0, 4)), rand_byte(), 2'($urandom_range(0, 3)));
    run_phase(250);

    noise_pct = 10;
    calm <= 1'b1;
    set_config(16'($urandom_range(2, 40)), 16'($urandom_range(2, 40)),
               6'($urandom_range(0, 63)), rand_byte(), 2'($urandom_range(0, 3)));
    run_phase(250);

    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (10) @(posedge clk);
    if (fail_count == 0) $display("ps2_mouse_host_engine test passed");
    else $display("ps2_mouse_host_engine test failed");
    $finish;
  end

endmodule
